### sv/hibp_pkg.sv
// Shared types and constants for the interleaved Hamming bit packer.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package hibp_pkg;

  localparam int SPP_W   = 18;
  localparam int INDEX_W = 23;
  localparam int CFG_AW  = 3;

  localparam logic [SPP_W-1:0] SPP_RESET = 18'd16384;

  // Register index of the only configuration register.
  localparam logic REG_SYMBOLS_PER_PAGE = 1'b0;

  // Item kinds on the input channel.
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Parity masks; entry i covers the parity bit at position 16 >> i.
  localparam logic [31:0] PARITY_MASK [5] = '{
    32'hffff0000, 32'hff00ff00, 32'hf0f0f0f0, 32'hcccccccc, 32'haaaaaaaa
  };

  // Status of the data word buffer as seen by the serializer.
  typedef struct packed {
    logic avail;
    logic last;
  } word_stat_t;

endpackage

`default_nettype wire

### sv/hibp_encode.sv
// Combinational extended Hamming encoder: data word in, codeword out.
// Depends on hibp_pkg for the parity masks.
`timescale 1ns / 1ps
`default_nettype none

module hibp_encode #(
  parameter int CODE_ORDER = 4
) (
  input  wire logic [(1 << CODE_ORDER) - CODE_ORDER - 2:0] data,
  output logic      [(1 << CODE_ORDER) - 1:0]              code
);

  localparam int CODE_BITS = 1 << CODE_ORDER;
  localparam int DATA_BITS = CODE_BITS - CODE_ORDER - 1;

  // Position of data bit j: the j-th position, counting up from 3, that is
  // not a power of two.
  function automatic int data_pos(input int j);
    int cnt;
    int res;
    cnt = -1;
    res = 0;
    for (int p = 3; p < 32; p++) begin
      if ((p & (p - 1)) != 0) begin
        cnt = cnt + 1;
        if (cnt == j) begin
          res = p;
          break;
        end
      end
    end
    return res;
  endfunction

  logic [CODE_BITS-1:0] spread;
  logic [CODE_BITS-1:0] with_par;

  genvar j, b;
  generate
    for (j = 0; j < CODE_BITS; j++) begin : g_clear
      if (j < 3 || (j & (j - 1)) == 0) begin : g_zero
        assign spread[j] = 1'b0;
      end
    end
    for (j = 0; j < DATA_BITS; j++) begin : g_data
      localparam int P = data_pos(j);
      assign spread[P] = data[j];
    end
    for (j = 0; j < CODE_BITS; j++) begin : g_copy
      if (j == 0 || (j & (j - 1)) != 0) begin : g_keep
        assign with_par[j] = spread[j];
      end
    end
    for (b = 0; b < CODE_ORDER; b++) begin : g_par
      localparam logic [31:0] M = hibp_pkg::PARITY_MASK[4-b];
      assign with_par[1 << b] = ^(spread & M[CODE_BITS-1:0]);
    end
  endgenerate

  // Overall parity at position 0 makes the whole codeword even.
  always_comb begin
    code    = with_par;
    code[0] = ^with_par[CODE_BITS-1:1];
  end

endmodule

`default_nettype wire

### sv/hibp_gather.sv
// Input register, bit accumulator and two-entry data word buffer.
// Depends on hibp_pkg for the item kinds and the word buffer status type.
`timescale 1ns / 1ps
`default_nettype none

module hibp_gather #(
  parameter int CODE_ORDER = 4
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst,
  input  wire logic                                           in_valid,
  output logic                                                in_ready,
  input  wire logic                                           in_op,
  input  wire logic [7:0]                                     in_byte,
  input  wire logic                                           pop,
  output hibp_pkg::word_stat_t                                stat,
  output logic      [(1 << CODE_ORDER) - CODE_ORDER - 2:0]    head_word
);

  localparam int CODE_BITS = 1 << CODE_ORDER;
  localparam int DATA_BITS = CODE_BITS - CODE_ORDER - 1;
  localparam int CNT_W     = $clog2(DATA_BITS + 1);

  logic                 a_valid;
  logic                 a_op;
  logic [7:0]           a_byte;
  logic [DATA_BITS-1:0] pend_bits;
  logic [CNT_W-1:0]     pend_cnt;
  logic [DATA_BITS-1:0] pend_bits_next;
  logic [CNT_W-1:0]     pend_cnt_next;
  logic [1:0]           n_words;
  logic [DATA_BITS-1:0] word0_next;
  logic [DATA_BITS-1:0] word1_next;
  logic [1:0]           b_cnt;
  logic [DATA_BITS-1:0] b_word0;
  logic [DATA_BITS-1:0] b_word1;
  logic                 b_free;
  logic                 a_move;

  // Shift the eight bits of a byte in, most significant first, cutting a
  // data word each time the accumulator fills. A flush pads with zeros.
  always_comb begin
    pend_bits_next = pend_bits;
    pend_cnt_next  = pend_cnt;
    n_words        = 2'd0;
    word0_next     = '0;
    word1_next     = '0;
    if (a_op == hibp_pkg::OP_DATA) begin
      for (int i = 7; i >= 0; i--) begin
        pend_bits_next = {pend_bits_next[DATA_BITS-2:0], a_byte[i]};
        pend_cnt_next  = pend_cnt_next + 1'b1;
        if (pend_cnt_next == CNT_W'(DATA_BITS)) begin
          if (n_words == 2'd0) begin
            word0_next = pend_bits_next;
          end else begin
            word1_next = pend_bits_next;
          end
          n_words        = n_words + 2'd1;
          pend_bits_next = '0;
          pend_cnt_next  = '0;
        end
      end
    end else if (pend_cnt != '0) begin
      word0_next     = pend_bits << (CNT_W'(DATA_BITS) - pend_cnt);
      n_words        = 2'd1;
      pend_bits_next = '0;
      pend_cnt_next  = '0;
    end
  end

  assign b_free   = (b_cnt == 2'd0) || ((b_cnt == 2'd1) && pop);
  assign a_move   = a_valid && ((n_words == 2'd0) || b_free);
  assign in_ready = !a_valid || a_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      pend_bits <= '0;
      pend_cnt  <= '0;
      b_cnt     <= 2'd0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (a_move) begin
        pend_bits <= pend_bits_next;
        pend_cnt  <= pend_cnt_next;
      end
      if (a_move && (n_words != 2'd0)) begin
        b_cnt <= n_words;
      end else if (pop) begin
        b_cnt <= b_cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_op   <= in_op;
      a_byte <= in_byte;
    end
    if (a_move && (n_words != 2'd0)) begin
      b_word0 <= word0_next;
      b_word1 <= word1_next;
    end else if (pop) begin
      b_word0 <= b_word1;
    end
  end

  assign stat.avail = (b_cnt != 2'd0);
  assign stat.last  = (b_cnt == 2'd1);
  assign head_word  = b_word0;

endmodule

`default_nettype wire

### sv/hibp_serialize.sv
// Codeword serializer: sends one codeword bit per cycle while out_ready is high,
// with its interleaved channel index; keeps the symbol counter. Depends on hibp_pkg, hibp_encode.
`timescale 1ns / 1ps
`default_nettype none

module hibp_serialize #(
  parameter int CODE_ORDER = 4
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst,
  input  wire logic [hibp_pkg::SPP_W-1:0]                     spp,
  input  wire hibp_pkg::word_stat_t                           stat,
  input  wire logic [(1 << CODE_ORDER) - CODE_ORDER - 2:0]    head_word,
  output logic                                                pop,
  output logic                                                out_valid,
  input  wire logic                                           out_ready,
  output logic                                                out_bit,
  output logic      [hibp_pkg::INDEX_W-1:0]                   out_index,
  output logic                                                out_new_page,
  output logic                                                out_last
);

  localparam int CODE_BITS = 1 << CODE_ORDER;

  logic [CODE_BITS-1:0]           code;
  logic [CODE_BITS-1:0]           s_word;
  logic [CODE_ORDER-1:0]          s_k;
  logic [hibp_pkg::INDEX_W-1:0]   s_idx;
  logic                           s_new_page;
  logic                           s_last_word;
  logic                           s_valid;
  logic [hibp_pkg::SPP_W-1:0]     symbol_number;
  logic [hibp_pkg::SPP_W-1:0]     sym_cur;
  logic                           s_done;

  hibp_encode #(
    .CODE_ORDER(CODE_ORDER)
  ) u_encode (
    .data (head_word),
    .code (code)
  );

  // A full page wraps the symbol number back to zero before the symbol goes out.
  assign sym_cur = (symbol_number >= spp) ? '0 : symbol_number;
  assign s_done  = s_valid && out_ready && (&s_k);
  assign pop     = stat.avail && (!s_valid || s_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid       <= 1'b0;
      symbol_number <= '0;
    end else if (pop) begin
      s_valid       <= 1'b1;
      symbol_number <= sym_cur + 1'b1;
    end else if (s_done) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s_word      <= code;
      s_k         <= '0;
      s_idx       <= hibp_pkg::INDEX_W'(sym_cur);
      s_new_page  <= (sym_cur == '0);
      s_last_word <= stat.last;
    end else if (s_valid && out_ready) begin
      s_word     <= {s_word[CODE_BITS-2:0], 1'b0};
      s_k        <= s_k + 1'b1;
      s_idx      <= s_idx + hibp_pkg::INDEX_W'(spp);
      s_new_page <= 1'b0;
    end
  end

  assign out_valid    = s_valid;
  assign out_bit      = s_word[CODE_BITS-1];
  assign out_index    = s_idx;
  assign out_new_page = s_new_page;
  assign out_last     = s_last_word && (&s_k);

endmodule

`default_nettype wire

### sv/hamming_interleaved_bit_packer.sv
// Interleaved extended Hamming bit packer: top level with the register port.
// Depends on hibp_pkg, hibp_gather, hibp_serialize and hibp_encode.
//
// Input items arrive on the s_ channel: s_tuser is the kind (data byte or
// flush) and s_tdata the payload byte. Bits are gathered most significant
// first; each full data word becomes a codeword of 2**CODE_ORDER bits.
// Result items leave on the m_ channel, one codeword bit per item, most
// significant bit first, with its interleaved channel index. m_tuser marks the
// first bit of the first symbol of a page; m_tlast marks the final result of
// an input item. A flush with bits pending sends one zero-padded codeword.
// The item completing a codeword passes the input register and the word buffer
// before the serializer register loads the codeword and puts its first bit on
// m_tdata. The output sends one bit per cycle while m_tready is high. The input
// keeps taking items while an input register and a two-word buffer have room.
// A stall on m_tready holds the current bit and backs up into s_tready.
// Reset empties the accumulator, clears the symbol counter, drops all queued
// words and sets symbols_per_page (byte address 0) to 16384.
`timescale 1ns / 1ps
`default_nettype none

module hamming_interleaved_bit_packer #(
  parameter int CODE_ORDER = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,   // [7:0] data_byte
  input  wire logic                          s_tuser,   // [0] op
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [23:0]                   m_tdata,   // [0] channel_bit, [23:1] channel_index
  output logic                               m_tuser,   // [0] new_page
  output logic                               m_tlast,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hibp_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  localparam int DATA_BITS = (1 << CODE_ORDER) - CODE_ORDER - 1;

  logic [hibp_pkg::SPP_W-1:0]     symbols_per_page;
  hibp_pkg::word_stat_t           stat;
  logic [DATA_BITS-1:0]           head_word;
  logic                           pop;
  logic                           out_bit;
  logic [hibp_pkg::INDEX_W-1:0]   out_index;
  logic                           reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == hibp_pkg::REG_SYMBOLS_PER_PAGE);

  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_per_page <= hibp_pkg::SPP_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      symbols_per_page <= pwdata[hibp_pkg::SPP_W-1:0];
    end
  end

  assign prdata = reg_sel ? 32'(symbols_per_page) : 32'd0;

  hibp_gather #(
    .CODE_ORDER(CODE_ORDER)
  ) u_gather (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_byte   (s_tdata),
    .pop       (pop),
    .stat      (stat),
    .head_word (head_word)
  );

  hibp_serialize #(
    .CODE_ORDER(CODE_ORDER)
  ) u_serialize (
    .clk          (clk),
    .rst          (rst),
    .spp          (symbols_per_page),
    .stat         (stat),
    .head_word    (head_word),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_bit      (out_bit),
    .out_index    (out_index),
    .out_new_page (m_tuser),
    .out_last     (m_tlast)
  );

  assign m_tdata = {out_index, out_bit};

  // The first bit of a page always sits at channel index zero.
  a_page_index : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[23:1] == 23'd0))
    else $error("new page flagged on a nonzero channel index");

  // Codewords of one item leave without a gap until the last result.
  a_no_gap : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("result stream broke before the last result of an item");

  // Reset drops anything that was being sent.
  a_reset_empty : assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

### dv/hamming_interleaved_bit_packer_tb.sv
// Self-checking testbench for the interleaved extended Hamming bit packer.
// Depends on hibp_pkg and hamming_interleaved_bit_packer; a built-in model of
// the packer predicts every codeword bit, channel index and flag.
`timescale 1ns / 1ps

module hamming_interleaved_bit_packer_tb;

  localparam int CODE_ORDER       = 4;
  localparam int CODE_BITS        = 1 << CODE_ORDER;
  localparam int DATA_BITS        = CODE_BITS - CODE_ORDER - 1;
  localparam int SETTLE_CYCLES    = 40;
  localparam int STALL_LIMIT      = 1000;
  localparam int RANDOM_PER_PHASE = 45;
  localparam int NUM_PHASES       = 7;
  localparam int NUM_DIRECTED     = 25;
  localparam int MAX_PRINTED      = 200;

  // Register index that decodes to nothing.
  localparam logic REG_UNUSED = 1'b1;
  localparam logic [hibp_pkg::CFG_AW-1:0] ADDR_SPP    =
    {hibp_pkg::REG_SYMBOLS_PER_PAGE, 2'b00};
  localparam logic [hibp_pkg::CFG_AW-1:0] ADDR_UNUSED = {REG_UNUSED, 2'b00};

  typedef struct packed {
    logic                         chan_bit;
    logic [hibp_pkg::INDEX_W-1:0] chan_index;
    logic                         new_page;
    logic                         last_flag;
  } chan_result_t;

  // A row with known set carries its expected codeword (or no result at all).
  typedef struct packed {
    logic        op;
    logic [7:0]  data;
    logic        known;
    logic [4:0]  count;
    logic [15:0] code;
  } stim_row_t;

  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{hibp_pkg::OP_FLUSH, 8'h00, 1'b1, 5'd0,  16'h0000},
    '{hibp_pkg::OP_DATA,  8'h00, 1'b1, 5'd0,  16'h0000},
    '{hibp_pkg::OP_DATA,  8'h00, 1'b1, 5'd16, 16'h0000},
    '{hibp_pkg::OP_FLUSH, 8'h00, 1'b1, 5'd16, 16'h0000},
    '{hibp_pkg::OP_FLUSH, 8'hff, 1'b1, 5'd0,  16'h0000},
    '{hibp_pkg::OP_DATA,  8'hff, 1'b1, 5'd0,  16'h0000},
    '{hibp_pkg::OP_DATA,  8'hff, 1'b1, 5'd16, 16'hffff},
    '{hibp_pkg::OP_DATA,  8'hff, 1'b1, 5'd16, 16'hffff},
    '{hibp_pkg::OP_FLUSH, 8'h00, 1'b0, 5'd0,  16'h0000},
    '{hibp_pkg::OP_DATA,  8'h80, 1'b0, 5'd0,  16'h0000},
    '{hibp_pkg::OP_DATA,  8'h00, 1'b0, 5'd0,  16'h0000},
    '{hibp_pkg::OP_DATA,  8'h01, 1'b0, 5'd0,  16'h0000},
    '{hibp_pkg::OP_DATA,  8'ha5, 1'b0, 5'd0,  16'h0000},
    '{hibp_pkg::OP_DATA,  8'h5a, 1'b0, 5'd0,  16'h0000},
    '{hibp_pkg::OP_DATA,  8'h0f, 1'b0, 5'd0,  16'h0000},
    '{hibp_pkg::OP_DATA,  8'hf0, 1'b0, 5'd0,  16'h0000},
    '{hibp_pkg::OP_FLUSH, 8'h00, 1'b0, 5'd0,  16'h0000},
    '{hibp_pkg::OP_DATA,  8'h7f, 1'b0, 5'd0,  16'h0000},
    '{hibp_pkg::OP_DATA,  8'hfe, 1'b0, 5'd0,  16'h0000},
    '{hibp_pkg::OP_DATA,  8'h3c, 1'b0, 5'd0,  16'h0000},
    '{hibp_pkg::OP_DATA,  8'hc3, 1'b0, 5'd0,  16'h0000},
    '{hibp_pkg::OP_FLUSH, 8'h00, 1'b0, 5'd0,  16'h0000},
    '{hibp_pkg::OP_DATA,  8'h55, 1'b0, 5'd0,  16'h0000},
    '{hibp_pkg::OP_DATA,  8'haa, 1'b0, 5'd0,  16'h0000},
    '{hibp_pkg::OP_FLUSH, 8'h00, 1'b0, 5'd0,  16'h0000}
  };

  // Page sizes of the random phases; the third one lowers the size mid-stream.
  localparam logic [hibp_pkg::SPP_W-1:0] PAGE_SIZES [NUM_PHASES] = '{
    18'd1, 18'd262143, 18'd3, 18'd0, 18'd2, 18'd16384, 18'd5
  };

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [7:0]                    s_tdata;
  logic                          s_tuser;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [23:0]                   m_tdata;
  logic                          m_tuser;
  logic                          m_tlast;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [hibp_pkg::CFG_AW-1:0]   paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  // Packer model state.
  logic [hibp_pkg::SPP_W-1:0]   page_size;
  logic [DATA_BITS-1:0]         gathered_bits;
  int                           gathered_count;
  logic [hibp_pkg::SPP_W-1:0]   symbol_count;

  chan_result_t codeword_bits_new [$];
  chan_result_t codeword_bits_due [$];

  stim_row_t cur_row;
  logic      no_gaps;
  int        mismatches;
  int        idle_cycles;
  bit        progress;
  chan_result_t got_bit;
  chan_result_t want_bit;

  hamming_interleaved_bit_packer #(
    .CODE_ORDER(CODE_ORDER)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [CODE_BITS-1:0] hamming_encode(input logic [DATA_BITS-1:0] d);
    logic [CODE_BITS-1:0] cw;
    int n;
    int p;
    int j;
    cw = '0;
    n = 0;
    // Data fills the positions that are neither 0 nor a power of two.
    for (j = 1; j < CODE_BITS; j++) begin
      if ((j & (j - 1)) != 0) begin
        cw[j] = d[n];
        n++;
      end
    end
    for (p = 1; p < CODE_BITS; p = p * 2) begin
      for (j = 1; j < CODE_BITS; j++) begin
        if ((j & p) != 0 && j != p) cw[p] = cw[p] ^ cw[j];
      end
    end
    cw[0] = ^cw;
    return cw;
  endfunction

  task automatic emit_symbol(input logic [DATA_BITS-1:0] d);
    logic [CODE_BITS-1:0] cw;
    logic [63:0] pos;
    chan_result_t r;
    int k;
    cw = hamming_encode(d);
    if (symbol_count >= page_size) symbol_count = '0;
    for (k = 0; k < CODE_BITS; k++) begin
      pos = 64'(symbol_count) + 64'(k) * 64'(page_size);
      r.chan_bit   = cw[CODE_BITS-1-k];
      r.chan_index = pos[hibp_pkg::INDEX_W-1:0];
      r.new_page   = (k == 0) && (symbol_count == '0);
      r.last_flag  = 1'b0;
      codeword_bits_new.push_back(r);
    end
    symbol_count = symbol_count + 1'b1;
  endtask

  task automatic pack_item(input logic op, input logic [7:0] data_in);
    int b;
    codeword_bits_new.delete();
    if (op == hibp_pkg::OP_DATA) begin
      for (b = 7; b >= 0; b--) begin
        gathered_bits = {gathered_bits[DATA_BITS-2:0], data_in[b]};
        gathered_count++;
        if (gathered_count >= DATA_BITS) begin
          emit_symbol(gathered_bits);
          gathered_bits  = '0;
          gathered_count = 0;
        end
      end
    end else if (gathered_count > 0) begin
      // Pad the pending bits with zeros below them.
      emit_symbol(gathered_bits << (DATA_BITS - gathered_count));
      gathered_bits  = '0;
      gathered_count = 0;
    end
    if (codeword_bits_new.size() > 0)
      codeword_bits_new[codeword_bits_new.size()-1].last_flag = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // Monitor: model update on every accepted item and register write, and check of every result.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      progress = 1'b0;
      if (psel && penable && pwrite && pready) begin
        if (paddr[hibp_pkg::CFG_AW-1:2] == hibp_pkg::REG_SYMBOLS_PER_PAGE)
          page_size = pwdata[hibp_pkg::SPP_W-1:0];
        progress = 1'b1;
      end
      if (s_tvalid && s_tready) begin
        pack_item(s_tuser, s_tdata);
        if (cur_row.known) begin
          if (cur_row.count == 5'd0) codeword_bits_new.delete();
          for (int k = 0; k < codeword_bits_new.size(); k++)
            codeword_bits_new[k].chan_bit = cur_row.code[CODE_BITS-1-k];
        end
        for (int k = 0; k < codeword_bits_new.size(); k++)
          codeword_bits_due.push_back(codeword_bits_new[k]);
        progress = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        got_bit = '{m_tdata[0], m_tdata[23:1], m_tuser, m_tlast};
        if (codeword_bits_due.size() == 0) begin
          report_mismatch("result with none expected, index", got_bit.chan_index, 0);
        end else begin
          want_bit = codeword_bits_due.pop_front();
          if (got_bit.chan_bit !== want_bit.chan_bit)
            report_mismatch("channel_bit", got_bit.chan_bit, want_bit.chan_bit);
          if (got_bit.chan_index !== want_bit.chan_index)
            report_mismatch("channel_index", got_bit.chan_index, want_bit.chan_index);
          if (got_bit.new_page !== want_bit.new_page)
            report_mismatch("new_page", got_bit.new_page, want_bit.new_page);
          if (got_bit.last_flag !== want_bit.last_flag)
            report_mismatch("last", got_bit.last_flag, want_bit.last_flag);
        end
        progress = 1'b1;
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    idle_cycles = 0;
    @(negedge clk);
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // Result side: m_tready drops for a freshly drawn random stall before every result, unless no_gaps is set.
  initial begin
    int stall;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input stim_row_t row);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_row = row;
    s_tvalid <= 1'b1;
    s_tuser  <= row.op;
    s_tdata  <= row.data;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [hibp_pkg::CFG_AW-1:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop sending, wait for every expected bit, then let the pipeline settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (codeword_bits_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    stim_row_t row;
    int pick;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = hibp_pkg::OP_DATA;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    cur_row        = '0;
    no_gaps        = 1'b0;
    mismatches     = 0;
    page_size      = hibp_pkg::SPP_RESET;
    gathered_bits  = '0;
    gathered_count = 0;
    symbol_count   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) send_item(DIRECTED[i]);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 3) write_reg(ADDR_UNUSED, $urandom());
      write_reg(ADDR_SPP, {14'($urandom()), PAGE_SIZES[ph]});
      no_gaps = (ph == 2) || (ph == 5);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        row       = '0;
        row.op    = ($urandom_range(0, 7) == 0) ? hibp_pkg::OP_FLUSH : hibp_pkg::OP_DATA;
        pick      = $urandom_range(0, 9);
        row.data  = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom());
        send_item(row);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
